// ===== design/i2c_master_write_waveform_macros.svh =====
// assertion macros shared by the i2c master write waveform modules
// depends on nothing; included by files that carry assertions
`ifndef I2C_MASTER_WRITE_WAVEFORM_MACROS_SVH
`define I2C_MASTER_WRITE_WAVEFORM_MACROS_SVH

// antecedent implies consequent in the same cycle
`define I2CW_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cw assertion failed");

// antecedent implies consequent in the next cycle
`define I2CW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cw assertion failed");

`endif

// ===== design/i2cw_pkg.sv =====
// types and constants for the i2c master write waveform generator
// no dependencies
`default_nettype none

package i2cw_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [3:0] HOLD_SHORT    = 4'd1;
  localparam logic [3:0] HOLD_SETUP    = 4'd3;
  localparam logic [3:0] HOLD_HIGH     = 4'd5;
  localparam logic [3:0] HOLD_ACK_HIGH = 4'd10;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } byte_in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [3:0] hold_us;
    logic       last_segment;
  } seg_out_t;

  // classified byte as it travels through the queue
  typedef struct packed {
    logic [7:0] data_byte;
    logic       do_start;
    logic       do_stop;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_BITS,
    PH_ACK,
    PH_STOP
  } phase_t;

endpackage

`default_nettype wire

// ===== design/i2cw_front.sv =====
// front end: accepts input bytes into a holding register and forwards them to the queue
// depends on i2cw_pkg
`default_nettype none

module i2cw_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_stall,
  input  wire i2cw_pkg::byte_in_t  cmd_data,
  input  wire i2cw_pkg::q_status_t q_status,
  output logic                     q_push,
  output i2cw_pkg::cmd_t           q_wdata
);
  import i2cw_pkg::*;

  logic hold_valid;
  logic hold_valid_next;
  cmd_t hold;
  logic accept;

  assign q_push    = hold_valid && !q_status.full;
  assign cmd_stall = hold_valid && q_status.full;
  assign accept    = cmd_valid && !cmd_stall;
  assign q_wdata   = hold;

  always_comb begin
    hold_valid_next = hold_valid;
    if (accept) begin
      hold_valid_next = 1'b1;
    end else if (q_push) begin
      hold_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold.data_byte <= cmd_data.data_byte;
      hold.do_start  <= cmd_data.first_byte;
      hold.do_stop   <= cmd_data.last_byte;
    end
  end

endmodule

`default_nettype wire

// ===== design/i2cw_queue.sv =====
// short command queue between front end and sequencer
// depends on i2cw_pkg and the assertion macro header
`default_nettype none
`include "i2c_master_write_waveform_macros.svh"

module i2cw_queue #(
  parameter int DEPTH = i2cw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire i2cw_pkg::cmd_t wdata,
  input  wire logic           pop,
  output i2cw_pkg::cmd_t      rdata,
  output i2cw_pkg::q_status_t status
);
  import i2cw_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign rdata        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  `I2CW_ASSERT_IMPL(a_no_push_full, clk, rst, status.full, !push)
  `I2CW_ASSERT_IMPL(a_no_pop_empty, clk, rst, status.empty, !pop)
  `I2CW_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + CW'(1))

endmodule

`default_nettype wire

// ===== design/i2cw_back.sv =====
// back end: segment sequencer with output register
// depends on i2cw_pkg and the assertion macro header
`default_nettype none
`include "i2c_master_write_waveform_macros.svh"

module i2cw_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire i2cw_pkg::q_status_t q_status,
  input  wire i2cw_pkg::cmd_t      q_rdata,
  output logic                     q_pop,
  output logic                     seg_valid,
  input  wire logic                seg_stall,
  output i2cw_pkg::seg_out_t       seg_data
);
  import i2cw_pkg::*;

  phase_t     phase, phase_next;
  logic       busy, busy_next;
  logic [1:0] sub, sub_next;
  logic [2:0] bit_cnt, bit_cnt_next;
  logic [7:0] shift, shift_next;
  logic       stop_flag, stop_flag_next;
  logic       seg_valid_next;
  seg_out_t   seg;
  logic       advance;

  assign advance = !seg_valid || !seg_stall;

  always_comb begin
    seg            = '0;
    phase_next     = phase;
    sub_next       = sub;
    bit_cnt_next   = bit_cnt;
    shift_next     = shift;
    stop_flag_next = stop_flag;
    busy_next      = busy;
    q_pop          = 1'b0;

    case (phase)
      PH_START: begin
        case (sub)
          2'd0: seg = '{1'b1, 1'b1, HOLD_SHORT, 1'b0};
          2'd1: seg = '{1'b1, 1'b1, HOLD_HIGH, 1'b0};
          2'd2: seg = '{1'b1, 1'b0, HOLD_HIGH, 1'b0};
          default: seg = '{1'b0, 1'b0, HOLD_SETUP, 1'b0};
        endcase
      end
      PH_BITS: begin
        seg.scl_level = (sub == 2'd1);
        seg.sda_level = shift[7];
        seg.hold_us   = (sub == 2'd1) ? HOLD_HIGH : HOLD_SETUP;
      end
      PH_ACK: begin
        seg.scl_level    = (sub == 2'd1);
        seg.sda_level    = 1'b1;
        seg.hold_us      = (sub == 2'd1) ? HOLD_ACK_HIGH : HOLD_SETUP;
        seg.last_segment = (sub == 2'd2) && !stop_flag;
      end
      PH_STOP: begin
        seg.scl_level    = (sub != 2'd0);
        seg.sda_level    = (sub == 2'd2);
        seg.hold_us      = (sub == 2'd2) ? HOLD_HIGH : HOLD_SETUP;
        seg.last_segment = (sub == 2'd2);
      end
      default: seg = '0;
    endcase

    if (advance && busy) begin
      sub_next = sub + 2'd1;
      case (phase)
        PH_START: begin
          if (sub == 2'd3) begin
            phase_next = PH_BITS;
            sub_next   = 2'd0;
          end
        end
        PH_BITS: begin
          if (sub == 2'd2) begin
            sub_next     = 2'd0;
            shift_next   = {shift[6:0], 1'b0};
            bit_cnt_next = bit_cnt + 3'd1;
            if (bit_cnt == LAST_BIT) begin
              phase_next = PH_ACK;
            end
          end
        end
        PH_ACK: begin
          if (sub == 2'd2) begin
            phase_next = PH_STOP;
            sub_next   = 2'd0;
          end
        end
        default: begin
          if (sub == 2'd2) begin
            sub_next = 2'd0;
          end
        end
      endcase
      if (seg.last_segment) begin
        busy_next = 1'b0;
      end
    end

    // take the next byte when idle or on the final segment of the current one
    if (advance && !q_status.empty && (!busy || seg.last_segment)) begin
      q_pop          = 1'b1;
      busy_next      = 1'b1;
      shift_next     = q_rdata.data_byte;
      stop_flag_next = q_rdata.do_stop;
      phase_next     = q_rdata.do_start ? PH_START : PH_BITS;
      sub_next       = 2'd0;
      bit_cnt_next   = 3'd0;
    end

    seg_valid_next = advance ? busy : seg_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_BITS;
      busy      <= 1'b0;
      sub       <= 2'd0;
      bit_cnt   <= 3'd0;
      seg_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      busy      <= busy_next;
      sub       <= sub_next;
      bit_cnt   <= bit_cnt_next;
      seg_valid <= seg_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    shift     <= shift_next;
    stop_flag <= stop_flag_next;
    if (advance) begin
      seg_data <= seg;
    end
  end

  `I2CW_ASSERT_IMPL(a_stop_needs_flag, clk, rst, busy && phase == PH_STOP, stop_flag)
  `I2CW_ASSERT_IMPL(a_start_at_bit0, clk, rst, busy && phase == PH_START, bit_cnt == 3'd0)
  `I2CW_ASSERT_NEXT(a_idle_after_last, clk, rst,
                    busy && advance && seg.last_segment && !q_pop, !busy)
  `I2CW_ASSERT_IMPL(a_hold_codes, clk, rst, seg_valid,
                    seg_data.hold_us == HOLD_SHORT || seg_data.hold_us == HOLD_SETUP ||
                    seg_data.hold_us == HOLD_HIGH || seg_data.hold_us == HOLD_ACK_HIGH)

endmodule

`default_nettype wire

// ===== design/i2c_master_write_waveform.sv =====
// i2c master write waveform generator, top level
// depends on i2cw_pkg, i2cw_front, i2cw_queue, i2cw_back
//
// usage:
//   cmd channel (cmd_valid / cmd_stall / cmd_data) takes one byte per transaction
//   with flags for a start condition before it and a stop condition after it.
//   seg channel (seg_valid / seg_stall / seg_data) returns one timed pin segment
//   per transaction: scl and sda levels, hold time in microseconds, and a flag
//   on the final segment of each byte.
//   a byte yields 27 segments, plus 4 with start and 3 with stop (27 to 34).
//   path: a byte taken on cmd passes through the front holding register, a queue
//   slot and the sequencer state before its first segment is registered on seg.
//   flow: one segment per cycle from the back-end sequencer while seg is not
//   stalled; the next byte follows its predecessor's final segment without a gap
//   when it is already queued. the front holding register and the queue buffer up to
//   QUEUE_DEPTH + 1 bytes ahead of the sequencer.
//   a stall on seg holds the segment and freezes the sequencer; the front keeps
//   taking bytes until queue and holding register are full, then raises cmd_stall.
//   reset empties the queue and both holding stages; no segment is pending.
`default_nettype none

module i2c_master_write_waveform #(
  parameter int QUEUE_DEPTH = i2cw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire i2cw_pkg::byte_in_t cmd_data,
  output logic                    seg_valid,
  input  wire logic               seg_stall,
  output i2cw_pkg::seg_out_t      seg_data
);
  import i2cw_pkg::*;

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  cmd_t      q_wdata;
  cmd_t      q_rdata;

  i2cw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  i2cw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  i2cw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .seg_valid (seg_valid),
    .seg_stall (seg_stall),
    .seg_data  (seg_data)
  );

endmodule

`default_nettype wire

// ===== verif/i2c_master_write_waveform_test.sv =====
`timescale 1ns / 100ps
// testbench for the i2c master write waveform generator: bytes in, timed pin segments out
// depends on i2cw_pkg and i2c_master_write_waveform; self-checking against its own segment predictor

module i2c_master_write_waveform_test;
  import i2cw_pkg::*;

  localparam int RANDOM_ITEMS    = 256;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int IDLE_LIMIT      = 3000;
  localparam int DRAIN_CYCLES    = 40;

  // expands each accepted byte into its pin segments and checks them in order
  class segment_tracker;
    seg_out_t expected_segs[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function void push_seg(logic scl, logic sda, logic [3:0] hold);
      seg_out_t s;
      s.scl_level    = scl;
      s.sda_level    = sda;
      s.hold_us      = hold;
      s.last_segment = 1'b0;
      expected_segs.push_back(s);
    endfunction

    function void note_byte(byte_in_t b);
      logic [7:0] shift;
      logic       bit_val;
      shift = b.data_byte;
      if (b.first_byte) begin
        push_seg(1'b1, 1'b1, HOLD_SHORT);
        push_seg(1'b1, 1'b1, HOLD_HIGH);
        push_seg(1'b1, 1'b0, HOLD_HIGH);
        push_seg(1'b0, 1'b0, HOLD_SETUP);
      end
      for (int i = 0; i < 8; i++) begin
        bit_val = shift[7];
        push_seg(1'b0, bit_val, HOLD_SETUP);
        push_seg(1'b1, bit_val, HOLD_HIGH);
        push_seg(1'b0, bit_val, HOLD_SETUP);
        shift = shift << 1;
      end
      // ack clock with sda released, ack not sampled
      push_seg(1'b0, 1'b1, HOLD_SETUP);
      push_seg(1'b1, 1'b1, HOLD_ACK_HIGH);
      push_seg(1'b0, 1'b1, HOLD_SETUP);
      if (b.last_byte) begin
        push_seg(1'b0, 1'b0, HOLD_SETUP);
        push_seg(1'b1, 1'b0, HOLD_SETUP);
        push_seg(1'b1, 1'b1, HOLD_HIGH);
      end
      expected_segs[expected_segs.size() - 1].last_segment = 1'b1;
    endfunction

    function void check_segment(seg_out_t got);
      seg_out_t exp_seg;
      if (expected_segs.size() == 0) begin
        $error("segment with none expected: scl %0d sda %0d hold %0d last %0d",
               got.scl_level, got.sda_level, got.hold_us, got.last_segment);
        errors++;
        return;
      end
      exp_seg = expected_segs.pop_front();
      if (got.scl_level !== exp_seg.scl_level) begin
        $error("scl_level: expected %0d, got %0d", exp_seg.scl_level, got.scl_level);
        errors++;
      end
      if (got.sda_level !== exp_seg.sda_level) begin
        $error("sda_level: expected %0d, got %0d", exp_seg.sda_level, got.sda_level);
        errors++;
      end
      if (got.hold_us !== exp_seg.hold_us) begin
        $error("hold_us: expected %0d, got %0d", exp_seg.hold_us, got.hold_us);
        errors++;
      end
      if (got.last_segment !== exp_seg.last_segment) begin
        $error("last_segment: expected %0d, got %0d", exp_seg.last_segment, got.last_segment);
        errors++;
      end
    endfunction

    function int pending();
      return expected_segs.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_stall;
  byte_in_t cmd_data = '0;
  logic     seg_valid;
  logic     seg_stall = 1'b0;
  seg_out_t seg_data;

  segment_tracker trk = new();
  byte_in_t       byte_q[$];
  bit             hold_off_req = 1'b0;
  int             idle_cycles = 0;

  i2c_master_write_waveform dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .seg_valid (seg_valid),
    .seg_stall (seg_stall),
    .seg_data  (seg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic add_byte(input logic [7:0] data, input logic first, input logic last);
    byte_in_t b;
    b.data_byte  = data;
    b.first_byte = first;
    b.last_byte  = last;
    byte_q.push_back(b);
  endtask

  task automatic send_byte(input byte_in_t b);
    cmd_valid <= 1'b1;
    cmd_data  <= b;
    do @(posedge clk); while (cmd_stall);
    trk.note_byte(b);
  endtask

  // play out the queued bytes; bursts of random length with random gaps unless back to back
  task automatic play_bytes(input bit back_to_back);
    int burst;
    int gap;
    while (byte_q.size() != 0) begin
      burst = $urandom_range(1, 10);
      while (burst > 0 && byte_q.size() != 0) begin
        send_byte(byte_q.pop_front());
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0 || back_to_back) ? 0 : $urandom_range(1, 40);
      if (gap > 0 && byte_q.size() != 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    cmd_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (trk.pending() != 0) @(posedge clk);
  endtask

  // receiver stall pattern, with a long hold-off on request
  initial begin : seg_sink
    int mode;
    int span;
    int tick;
    mode = 0;
    span = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        seg_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(20, 150);
        end
        span--;
        tick++;
        case (mode)
          0: seg_stall <= 1'b0;
          1: seg_stall <= ($urandom_range(0, 99) < 30);
          2: seg_stall <= (tick % 5 == 0) || (tick % 7 == 0);
          default: seg_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && seg_valid && !seg_stall) trk.check_segment(seg_data);
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (seg_valid && !seg_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim
    int count;
    int msg_len;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, single and multi byte messages
    add_byte(8'h00, 1'b1, 1'b1);
    add_byte(8'hFF, 1'b1, 1'b1);
    add_byte(8'h80, 1'b1, 1'b0);
    add_byte(8'h01, 1'b0, 1'b0);
    add_byte(8'hAA, 1'b0, 1'b1);
    // byte without start after a stop, then a repeated start mid message
    add_byte(8'h55, 1'b0, 1'b0);
    add_byte(8'h7F, 1'b1, 1'b0);
    add_byte(8'hFE, 1'b1, 1'b0);
    add_byte(8'hC3, 1'b0, 1'b1);
    add_byte(8'h3C, 1'b0, 1'b1);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b1);
    play_bytes(1'b0);

    // sender pauses until everything is out
    @(posedge clk);
    wait_drained();

    // long receiver hold-off while bytes keep coming, so the input backs up
    hold_off_req = 1'b1;
    for (int i = 0; i < 12; i++) add_byte(8'($urandom_range(0, 255)), i == 0, i == 11);
    play_bytes(1'b1);
    wait_drained();

    // random: mostly well-formed messages, some bytes with random flags
    count = 0;
    while (count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 15) begin
        add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
        count++;
      end else begin
        msg_len = $urandom_range(1, 5);
        for (int i = 0; i < msg_len; i++)
          add_byte(8'($urandom_range(0, 255)), i == 0, i == msg_len - 1);
        count += msg_len;
      end
    end
    play_bytes(1'b0);

    @(posedge clk);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (trk.errors == 0 && trk.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
